// ===== hdl/cct_pkg.sv =====
`default_nettype none
package cct_pkg;

    localparam int PosW  = 32;
    localparam int QuatW = 16;

    // register stages from input capture to the output register
    localparam int Stages = 5;

    typedef enum logic [2:0] {
        REG_POS_X  = 3'd0,
        REG_POS_Y  = 3'd1,
        REG_POS_Z  = 3'd2,
        REG_SCL_X  = 3'd3,
        REG_SCL_Y  = 3'd4,
        REG_SCL_Z  = 3'd5,
        REG_ORIENT = 3'd6,
        REG_PRESENT = 3'd7
    } reg_idx_t;

    // how an item is treated as it travels down the pipe
    typedef enum logic [1:0] {
        MODE_DEFAULT = 2'd0,
        MODE_PASS    = 2'd1,
        MODE_COMPOSE = 2'd2
    } mode_t;

    typedef logic signed [PosW-1:0]  pos_t;
    typedef logic signed [QuatW-1:0] quat_t;

    // saturate a signed 66-bit value to 32 bits
    function automatic pos_t sat32(input logic signed [65:0] x);
        pos_t r;
        if (x > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic quat_t sat16(input logic signed [35:0] x);
        quat_t r;
        if (x > 36'sd32767)
            r = 16'sh7fff;
        else if (x < -36'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/compose_child_transform.sv =====
`default_nettype none
// Composes a child node transform with a parent transform held in configuration
// registers. Position = parent position + child position rotated by the parent
// quaternion; scale = componentwise product; orientation = parent * child
// (Hamilton product, no renormalization). All values saturate. Fixed point:
// positions and scales Q16.16, quaternions Q2.14, rounding half up. With
// parent_present low the child passes through; an absent child yields the
// identity transform. The block is a five-stage pipeline (input capture, the
// first multiplier rank, rounding, the second multiplier rank, and the output
// register as the last stage); it takes one transfer per cycle when not stalled,
// and a stall on m_tready freezes all stages. Config writes (cfg_index:
// register 0..7 in list order) are always ready and must only occur while the
// pipeline is empty.
module compose_child_transform (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, quat_w, quat_x, quat_y, quat_z
    input  wire  [255:0] s_tdata,
    // child_present
    input  wire         s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, quat_w, quat_x, quat_y, quat_z
    output logic [255:0] m_tdata
);

    // configuration registers
    cct_pkg::pos_t pp_reg [3];
    cct_pkg::pos_t ps_reg [3];
    logic [63:0]   po_reg;
    logic          pres_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pp_reg[i] <= '0;
                ps_reg[i] <= 32'sd65536;
            end
            po_reg   <= 64'h4000000000000000;
            pres_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cct_pkg::reg_idx_t'(cfg_index))
                cct_pkg::REG_POS_X:   pp_reg[0] <= cfg_data[31:0];
                cct_pkg::REG_POS_Y:   pp_reg[1] <= cfg_data[31:0];
                cct_pkg::REG_POS_Z:   pp_reg[2] <= cfg_data[31:0];
                cct_pkg::REG_SCL_X:   ps_reg[0] <= cfg_data[31:0];
                cct_pkg::REG_SCL_Y:   ps_reg[1] <= cfg_data[31:0];
                cct_pkg::REG_SCL_Z:   ps_reg[2] <= cfg_data[31:0];
                cct_pkg::REG_ORIENT:  po_reg    <= cfg_data;
                cct_pkg::REG_PRESENT: pres_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] pw, pu [3];
    assign pw    = po_reg[63:48];
    assign pu[0] = po_reg[47:32];
    assign pu[1] = po_reg[31:16];
    assign pu[2] = po_reg[15:0];

    // pipeline control: whole pipe advances unless output stalled
    logic adv;
    logic [cct_pkg::Stages-1:0] vld_reg;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[cct_pkg::Stages-1];

    always_ff @(posedge aclk) begin
        if (!aresetn)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[cct_pkg::Stages-2:0], s_tvalid};
    end

    // stage 1: capture input, mode
    cct_pkg::pos_t v1_reg [3];
    cct_pkg::pos_t cs1_reg [3];
    cct_pkg::quat_t cq1_reg [4];
    cct_pkg::mode_t mode1_reg;

    // stage 2: cross products u x v (exact), scale and quat products
    logic signed [48:0] x2_reg [3][2];
    logic signed [63:0] sp2_reg [3];
    logic signed [31:0] qp2_reg [4][4];
    // stage 3: c1 rounded, scale rounded, quat sums rounded
    logic signed [35:0] c13_reg [3];
    // stage 4: w*c1 and u x c1 products
    logic signed [52:0] w4_reg [3];
    logic signed [52:0] x4_reg [3][2];
    // stage 5 output register
    logic [255:0] out_reg;

    // per-stage pass-through payload
    cct_pkg::pos_t v2_reg [3], v3_reg [3], v4_reg [3];
    cct_pkg::pos_t cs2_reg [3];
    cct_pkg::quat_t cq2_reg [4];
    cct_pkg::pos_t rs3_reg [3], rs4_reg [3];
    cct_pkg::quat_t rq3_reg [4], rq4_reg [4];
    cct_pkg::mode_t mode2_reg, mode3_reg, mode4_reg;

    logic signed [48:0] xd [3];
    logic signed [35:0] c1_n [3];
    logic signed [65:0] sr_n [3];
    logic signed [35:0] qs_n [4];
    logic signed [53:0] t_n [3];
    logic signed [65:0] p_n [3];
    logic [255:0] out_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xd[i]   = x2_reg[i][0] - x2_reg[i][1];
            c1_n[i] = 36'(($signed({xd[i][48], xd[i]}) + 50'sd8192) >>> 14);
            sr_n[i] = 66'((sp2_reg[i] + 64'sd32768) >>> 16);
        end
        qs_n[0] = 36'(qp2_reg[0][0]) - 36'(qp2_reg[0][1]) - 36'(qp2_reg[0][2])
                - 36'(qp2_reg[0][3]);
        for (int k = 1; k < 4; k++)
            qs_n[k] = 36'(qp2_reg[k][0]) + 36'(qp2_reg[k][1]) + 36'(qp2_reg[k][2])
                    - 36'(qp2_reg[k][3]);
        for (int i = 0; i < 3; i++) begin
            t_n[i] = 54'((55'(w4_reg[i]) + 55'(x4_reg[i][0]) - 55'(x4_reg[i][1])
                     + 55'sd4096) >>> 13);
            p_n[i] = 66'(pp_reg[i]) + 66'(v4_reg[i]) + 66'(t_n[i]);
        end
        out_next = '0;
        for (int i = 0; i < 3; i++) begin
            case (mode4_reg)
                cct_pkg::MODE_DEFAULT: begin
                    out_next[32*i +: 32]     = '0;
                    out_next[96+32*i +: 32]  = 32'd65536;
                end
                cct_pkg::MODE_PASS: begin
                    out_next[32*i +: 32]     = v4_reg[i];
                    out_next[96+32*i +: 32]  = rs4_reg[i];
                end
                default: begin
                    out_next[32*i +: 32]     = cct_pkg::sat32(p_n[i]);
                    out_next[96+32*i +: 32]  = rs4_reg[i];
                end
            endcase
        end
        for (int k = 0; k < 4; k++)
            out_next[192+16*k +: 16] = (mode4_reg == cct_pkg::MODE_DEFAULT)
                ? ((k == 0) ? 16'd16384 : 16'd0) : rq4_reg[k];
    end

    // stage registers, all advancing on adv; stage 2 forms the Hamilton product terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            for (int i = 0; i < 3; i++) begin
                v1_reg[i]  <= s_tdata[32*i +: 32];
                cs1_reg[i] <= s_tdata[96+32*i +: 32];
            end
            for (int k = 0; k < 4; k++)
                cq1_reg[k] <= s_tdata[192+16*k +: 16];
            if (!s_tuser)
                mode1_reg <= cct_pkg::MODE_DEFAULT;
            else if (pres_reg)
                mode1_reg <= cct_pkg::MODE_COMPOSE;
            else
                mode1_reg <= cct_pkg::MODE_PASS;
            // stage 2
            x2_reg[0][0] <= pu[1] * v1_reg[2];
            x2_reg[0][1] <= pu[2] * v1_reg[1];
            x2_reg[1][0] <= pu[2] * v1_reg[0];
            x2_reg[1][1] <= pu[0] * v1_reg[2];
            x2_reg[2][0] <= pu[0] * v1_reg[1];
            x2_reg[2][1] <= pu[1] * v1_reg[0];
            for (int i = 0; i < 3; i++) begin
                sp2_reg[i] <= ps_reg[i] * cs1_reg[i];
                v2_reg[i]  <= v1_reg[i];
                cs2_reg[i] <= cs1_reg[i];
            end
            qp2_reg[0][0] <= pw * cq1_reg[0];
            qp2_reg[0][1] <= pu[0] * cq1_reg[1];
            qp2_reg[0][2] <= pu[1] * cq1_reg[2];
            qp2_reg[0][3] <= pu[2] * cq1_reg[3];
            qp2_reg[1][0] <= pw * cq1_reg[1];
            qp2_reg[1][1] <= pu[0] * cq1_reg[0];
            qp2_reg[1][2] <= pu[1] * cq1_reg[3];
            qp2_reg[1][3] <= pu[2] * cq1_reg[2];
            qp2_reg[2][0] <= pw * cq1_reg[2];
            qp2_reg[2][1] <= pu[1] * cq1_reg[0];
            qp2_reg[2][2] <= pu[2] * cq1_reg[1];
            qp2_reg[2][3] <= pu[0] * cq1_reg[3];
            qp2_reg[3][0] <= pw * cq1_reg[3];
            qp2_reg[3][1] <= pu[2] * cq1_reg[0];
            qp2_reg[3][2] <= pu[0] * cq1_reg[2];
            qp2_reg[3][3] <= pu[1] * cq1_reg[1];
            cq2_reg   <= cq1_reg;
            mode2_reg <= mode1_reg;
            // stage 3
            for (int i = 0; i < 3; i++) begin
                c13_reg[i] <= c1_n[i];
                v3_reg[i]  <= v2_reg[i];
                rs3_reg[i] <= (mode2_reg == cct_pkg::MODE_COMPOSE)
                    ? cct_pkg::sat32(sr_n[i]) : cs2_reg[i];
            end
            for (int k = 0; k < 4; k++)
                rq3_reg[k] <= (mode2_reg == cct_pkg::MODE_COMPOSE)
                    ? cct_pkg::sat16((qs_n[k] + 36'sd8192) >>> 14) : cq2_reg[k];
            mode3_reg <= mode2_reg;
            // stage 4
            for (int i = 0; i < 3; i++)
                w4_reg[i] <= pw * c13_reg[i];
            x4_reg[0][0] <= pu[1] * c13_reg[2];
            x4_reg[0][1] <= pu[2] * c13_reg[1];
            x4_reg[1][0] <= pu[2] * c13_reg[0];
            x4_reg[1][1] <= pu[0] * c13_reg[2];
            x4_reg[2][0] <= pu[0] * c13_reg[1];
            x4_reg[2][1] <= pu[1] * c13_reg[0];
            v4_reg    <= v3_reg;
            rs4_reg   <= rs3_reg;
            rq4_reg   <= rq3_reg;
            mode4_reg <= mode3_reg;
            // stage 5
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    // a stalled output holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output changed under stall");
    // an accepted input enters the first stage with its valid bit
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("valid bit lost");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire
